FILE: src/pfc_pkg.sv
// pfc_pkg: types and constants shared by the packet frame counter modules
// no dependencies; imported by every module of the block

package pfc_pkg;

  // input item and result item as seen on the ports
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] packet_len;
    logic        start_of_packet;
  } pfc_in_t;

  typedef struct packed {
    logic [10:0] frame_count;
    logic        parse_error;
  } pfc_out_t;

  // framing selected by the low bits of the mode byte
  typedef enum logic [2:0] {
    FC_SINGLE  = 3'd0,
    FC_DOUBLE  = 3'd1,
    FC_TRIPLE  = 3'd2,
    FC_CBR     = 3'd3,
    FC_DOUBLE2 = 3'd4,
    FC_TRIPLE2 = 3'd5,
    FC_VAR1    = 3'd6,
    FC_VAR2    = 3'd7
  } framing_t;

  // end-of-packet summary passed from the parser to the finisher
  typedef struct packed {
    framing_t    framing_code;
    logic [11:0] packet_len;
    logic        hard_error;
    logic        awaiting;
    logic [10:0] fixed_frame_len;
    logic [11:0] consumed_total;
    logic [11:0] frames_seen;
  } pfc_rec_t;

  localparam logic [7:0]  EXT_THRESHOLD = 8'd252;
  localparam logic [11:0] MAX12         = 12'hFFF;
  localparam logic [10:0] MAX_COUNT     = 11'h7FF;

  // summary queue between parser and finisher
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // shift-subtract divider for the constant-bitrate framing
  localparam int DIV_STEPS = 12;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // long length field: 4*b1 + (b0 & 3) + 252
  function automatic logic [10:0] ext_length(input logic [1:0] low_bits,
                                             input logic [7:0] b1);
    ext_length = 11'({b1, 2'b00}) + 11'(low_bits) + 11'(EXT_THRESHOLD);
  endfunction

endpackage

FILE: src/pfc_front.sv
// pfc_front: byte-wise packet parser, keeps per-packet state and emits a summary
// on the last byte of each packet; depends on pfc_pkg

module pfc_front import pfc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  pfc_in_t  item,
  output logic     rec_push,
  output pfc_rec_t rec
);

  framing_t    code_r, code_nxt;
  logic [11:0] byte_idx_r, byte_idx_nxt;
  logic [11:0] nfp_r, nfp_nxt;
  logic [11:0] consumed_r, consumed_nxt;
  logic [11:0] frames_r, frames_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        await_r, await_nxt;
  logic [10:0] ffl_r, ffl_nxt;
  logic        err_r, err_nxt;

  logic [11:0] idx;
  logic [7:0]  b;
  logic [11:0] plen;
  logic        in_range;
  logic        last;
  logic [10:0] ext_len;
  logic        tf_do;
  logic [1:0]  tf_size;
  logic [10:0] tf_flen;
  logic [12:0] tf_total;

  assign b       = item.data_byte;
  assign plen    = item.packet_len;
  assign idx     = item.start_of_packet ? 12'd0 : byte_idx_r;
  assign ext_len = ext_length(pend_r, b);

  // position bookkeeping
  assign byte_idx_nxt = (idx != MAX12) ? idx + 12'd1 : idx;
  assign in_range     = (idx == 12'd0) || (idx < plen);
  assign last         = (plen == 12'd0) || ({1'b0, idx} + 13'd1 == {1'b0, plen});

  // next parse state for this byte
  always_comb begin
    code_nxt     = code_r;
    nfp_nxt      = nfp_r;
    consumed_nxt = consumed_r;
    frames_nxt   = frames_r;
    pend_nxt     = pend_r;
    await_nxt    = await_r;
    ffl_nxt      = ffl_r;
    err_nxt      = err_r;
    tf_do        = 1'b0;
    tf_size      = 2'd0;
    tf_flen      = 11'd0;
    tf_total     = 13'd0;
    if (idx == 12'd0) begin
      // mode byte opens a new packet
      code_nxt     = framing_t'(b[2:0]);
      nfp_nxt      = 12'd1;
      consumed_nxt = 12'd1;
      frames_nxt   = 12'd0;
      pend_nxt     = 2'd0;
      await_nxt    = 1'b0;
      ffl_nxt      = 11'd0;
      err_nxt      = 1'b0;
    end else if (idx < plen) begin
      if (code_r == FC_CBR) begin
        // single frame length after the mode byte
        if (idx == 12'd1) begin
          if (b >= EXT_THRESHOLD) begin
            pend_nxt  = b[1:0];
            await_nxt = 1'b1;
          end else begin
            ffl_nxt = 11'(b);
          end
        end else if (idx == 12'd2 && await_r) begin
          ffl_nxt   = ext_len;
          await_nxt = 1'b0;
        end
      end else if ((code_r == FC_VAR1 || code_r == FC_VAR2) && !err_r &&
                   consumed_r < plen) begin
        // walk the chain of length fields
        if (await_r) begin
          if ({1'b0, idx} == {1'b0, nfp_r} + 13'd1) begin
            await_nxt = 1'b0;
            tf_do     = 1'b1;
            tf_size   = 2'd2;
            tf_flen   = ext_len;
          end
        end else if (idx == nfp_r) begin
          if (b >= EXT_THRESHOLD) begin
            if (plen - consumed_r < 12'd2) begin
              err_nxt = 1'b1;
            end else begin
              pend_nxt  = b[1:0];
              await_nxt = 1'b1;
            end
          end else begin
            tf_do   = 1'b1;
            tf_size = (code_r == FC_VAR2) ? 2'd2 : 2'd1;
            tf_flen = 11'(b);
          end
        end
      end
      // account one field and its frame
      if (tf_do) begin
        tf_total     = {1'b0, consumed_r} + 13'(tf_size) + 13'(tf_flen);
        nfp_nxt      = nfp_r + 12'(tf_size);
        if (tf_total > {1'b0, plen}) err_nxt = 1'b1;
        consumed_nxt = (tf_total > {1'b0, MAX12}) ? MAX12 : tf_total[11:0];
        frames_nxt   = (frames_r != MAX12) ? frames_r + 12'd1 : frames_r;
      end
    end
  end

  // summary of the packet as it stands after this byte
  always_comb begin
    rec_push            = accept && in_range && last;
    rec.framing_code    = code_nxt;
    rec.packet_len      = plen;
    rec.hard_error      = err_nxt || (plen == 12'd0) ||
                          ({1'b0, plen} > 13'(MAX_PACKET_BYTES));
    rec.awaiting        = await_nxt;
    rec.fixed_frame_len = ffl_nxt;
    rec.consumed_total  = consumed_nxt;
    rec.frames_seen     = frames_nxt;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r     <= FC_SINGLE;
      byte_idx_r <= 12'd0;
      nfp_r      <= 12'd1;
      consumed_r <= 12'd1;
      frames_r   <= 12'd0;
      pend_r     <= 2'd0;
      await_r    <= 1'b0;
      ffl_r      <= 11'd0;
      err_r      <= 1'b0;
    end else if (accept) begin
      byte_idx_r <= byte_idx_nxt;
      if (in_range) begin
        code_r     <= code_nxt;
        nfp_r      <= nfp_nxt;
        consumed_r <= consumed_nxt;
        frames_r   <= frames_nxt;
        pend_r     <= pend_nxt;
        await_r    <= await_nxt;
        ffl_r      <= ffl_nxt;
        err_r      <= err_nxt;
      end
    end
  end

endmodule

FILE: src/pfc_queue.sv
// pfc_queue: short queue of packet summaries between parser and finisher
// depends on pfc_pkg

module pfc_queue import pfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pfc_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output pfc_rec_t head_rec
);

  pfc_rec_t          store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_rec = store_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_rec;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + (QPTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

endmodule

FILE: src/pfc_back.sv
// pfc_back: turns a packet summary into a frame count or error, with a
// shift-subtract divider for the constant-bitrate framing; depends on pfc_pkg

module pfc_back import pfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  pfc_rec_t q_rec,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output pfc_out_t out_item
);

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DIV, ST_DONE} state_t;

  state_t               state_r;
  pfc_rec_t             rec_r;
  logic [10:0]          rem_r;
  logic [11:0]          quo_r;
  logic [10:0]          div_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic                 out_valid_r;
  pfc_out_t             out_item_r;

  logic        slot_free;
  logic        out_load;
  logic [11:0] hdr;
  logic [11:0] payload;
  logic        cbr_bad;
  logic        eval_div;
  logic        eval_err;
  logic [10:0] eval_count;
  pfc_out_t    eval_res;
  logic [11:0] rem_shift;
  logic        sub_ok;
  pfc_out_t    div_res;

  assign slot_free = !out_valid_r || out_pop;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  // a new result enters the output register this cycle
  assign out_load  = slot_free &&
                     (((state_r == ST_EVAL) && !eval_div) || (state_r == ST_DONE));

  // header size and payload of a constant-bitrate packet
  assign hdr     = (rec_r.fixed_frame_len >= 11'(EXT_THRESHOLD)) ? 12'd3 : 12'd2;
  assign payload = rec_r.packet_len - hdr;
  assign cbr_bad = rec_r.hard_error || rec_r.awaiting ||
                   (rec_r.fixed_frame_len == 11'd0) ||
                   (rec_r.packet_len < 12'd2) || (rec_r.packet_len < hdr);

  // result of every framing but a well-formed constant-bitrate one
  always_comb begin
    eval_div   = 1'b0;
    eval_err   = rec_r.hard_error;
    eval_count = 11'd0;
    unique case (rec_r.framing_code)
      FC_SINGLE:             eval_count = 11'd1;
      FC_DOUBLE, FC_DOUBLE2: eval_count = 11'd2;
      FC_TRIPLE, FC_TRIPLE2: eval_count = 11'd3;
      FC_CBR: begin
        eval_err = cbr_bad;
        eval_div = !cbr_bad;
      end
      FC_VAR1, FC_VAR2: begin
        eval_err   = rec_r.hard_error || rec_r.awaiting ||
                     (rec_r.consumed_total != rec_r.packet_len);
        eval_count = (rec_r.frames_seen > 12'(MAX_COUNT)) ? MAX_COUNT :
                     rec_r.frames_seen[10:0];
      end
      default: eval_err = 1'b1;
    endcase
    eval_res.parse_error = eval_err;
    eval_res.frame_count = eval_err ? 11'd0 : eval_count;
  end

  // one divider step
  assign rem_shift = {rem_r, quo_r[11]};
  assign sub_ok    = (rem_shift >= {1'b0, div_r});

  // division outcome: exact multiple required
  always_comb begin
    div_res.parse_error = (rem_r != 11'd0);
    if (rem_r != 11'd0) begin
      div_res.frame_count = 11'd0;
    end else begin
      div_res.frame_count = (quo_r > 12'(MAX_COUNT)) ? MAX_COUNT : quo_r[10:0];
    end
  end

  // sequencer, divider and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_pop && out_valid_r && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            rec_r   <= q_rec;
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_div) begin
            rem_r   <= 11'd0;
            quo_r   <= payload;
            div_r   <= rec_r.fixed_frame_len;
            step_r  <= '0;
            state_r <= ST_DIV;
          end else if (slot_free) begin
            out_item_r  <= eval_res;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_DIV: begin
          rem_r  <= sub_ok ? 11'(rem_shift - {1'b0, div_r}) : rem_shift[10:0];
          quo_r  <= {quo_r[10:0], sub_ok};
          step_r <= step_r + DIV_CNT_W'(1);
          if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            out_item_r  <= div_res;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/packet_frame_counter_top.sv
// packet_frame_counter_top: packet frame counter, parser and finisher joined
// by a summary queue; depends on pfc_pkg, pfc_front, pfc_queue, pfc_back

// Bytes of a packet enter one per cycle on the in_ queue port while in_full
// is low, each carrying the packet length; the mode byte of each packet
// carries start_of_packet. The parser updates its state in the cycle a byte
// is taken and, on the last byte of a packet, writes a summary into a
// four-entry queue; in_full is high while that queue is full. The finisher
// turns each summary into one result and takes the next only when idle; the
// constant-bitrate framing also runs a twelve-step shift-subtract divider that
// checks the payload is a whole number of frames. Bytes past the end of a
// packet and bytes that are not last give no result.

module packet_frame_counter_top import pfc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  pfc_in_t  in_item,
  output logic     out_empty,
  input  logic     out_pop,
  output pfc_out_t out_item
);

  logic     accept;
  logic     rec_push;
  pfc_rec_t rec;
  logic     q_empty;
  logic     q_pop;
  pfc_rec_t q_rec;

  assign accept = in_push && !in_full;

  // byte parser
  pfc_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .rec_push (rec_push),
    .rec      (rec)
  );

  // summary queue
  pfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .full     (in_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_rec (q_rec)
  );

  // result finisher
  pfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

FILE: src/pfc_checker.sv
// pfc_checker: port-level checks on the packet frame counter, bound to the top
// level; depends on pfc_pkg and packet_frame_counter_top

module pfc_checker import pfc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_full,
  input logic     out_empty,
  input logic     out_pop,
  input pfc_out_t out_item
);

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // summary queue drained by reset
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full right after reset");

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

  // an error always reports a zero count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.parse_error) |-> (out_item.frame_count == 11'd0))
    else $error("error result with non-zero count");

endmodule

bind packet_frame_counter_top pfc_checker u_pfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);
